// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the pad coincidence RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TLPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pad coincidence assertion failed");
`define TLPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pad coincidence assertion failed");
`else
`define TLPC_ASSERT_IMP(lbl, ante, cons)
`define TLPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/tlpc_pkg.sv =====
// Package with types, codes and the reciprocal table of the pad coincidence block.
`default_nettype none

package tlpc_pkg;

    localparam int STRIP_W     = 10;
    localparam int XING_W      = 4;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int PAD_NUM_W   = 7;
    localparam int MASK_W      = 16;
    localparam int PAD_IDX_W   = 6;
    localparam int XING_IDX_W  = 5;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = STRIP_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic CMD_HIT   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic LAYER_FIRST  = 1'b0;
    localparam logic LAYER_SECOND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA_BX   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPS_PER_PAD = 1'd1;

    localparam logic [CFG_W-1:0] MAX_DELTA_BX_RESET   = 4'd1;
    localparam logic [CFG_W-1:0] STRIPS_PER_PAD_RESET = 4'd2;

    typedef struct packed {
        logic                  ok;
        logic [PAD_IDX_W-1:0]  pad;
        logic [XING_IDX_W-1:0] bit_idx;
    } hit_info_t;

    typedef struct packed {
        logic                  hit;
        logic                  layer;
        logic [PAD_IDX_W-1:0]  pad;
        logic [XING_IDX_W-1:0] bit_idx;
        logic                  shift;
    } cell_ctrl_t;

    // Rounded-up reciprocal scaled by 2**14; exact for any ten-bit dividend.
    function automatic logic [RECIP_W-1:0] recip(input logic [CFG_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            4'd0:    r = 15'd16384;
            4'd1:    r = 15'd16384;
            4'd2:    r = 15'd8192;
            4'd3:    r = 15'd5462;
            4'd4:    r = 15'd4096;
            4'd5:    r = 15'd3277;
            4'd6:    r = 15'd2731;
            4'd7:    r = 15'd2341;
            4'd8:    r = 15'd2048;
            4'd9:    r = 15'd1821;
            4'd10:   r = 15'd1639;
            4'd11:   r = 15'd1490;
            4'd12:   r = 15'd1366;
            4'd13:   r = 15'd1261;
            4'd14:   r = 15'd1171;
            4'd15:   r = 15'd1093;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tlpc_if.sv =====
// Channel interfaces of the pad coincidence block: hits, pad results and configuration.
`default_nettype none

interface tlpc_in_if;
    logic              valid;
    logic              ready;
    logic              command;
    logic              layer_sel;
    logic [9:0]        strip_number;
    logic signed [3:0] crossing;

    modport source (output valid, command, layer_sel, strip_number, crossing, input ready);
    modport sink (input valid, command, layer_sel, strip_number, crossing, output ready);
endinterface

interface tlpc_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  pad_number;
    logic [15:0] first_layer_mask;
    logic [15:0] second_layer_mask;
    logic [15:0] coincidence_mask;
    logic        last_pad;

    modport source (output valid, pad_number, first_layer_mask, second_layer_mask,
                    coincidence_mask, last_pad, input ready);
    modport sink (input valid, pad_number, first_layer_mask, second_layer_mask,
                  coincidence_mask, last_pad, output ready);
endinterface

interface tlpc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [3:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/two_layer_pad_coincidence_core.sv =====
// Top level of the two-layer pad coincidence builder.
//
//   Channel   Role   Carries
//   cfg       sink   register index and write data
//   hits      sink   command, layer_sel, strip_number, crossing
//   pads      source pad_number, three crossing masks, last_pad
//
// A hit transaction is taken outside a flush, passes the input pipeline register and then
// lands in its pad cell. A flush passes its pipeline register and the flushing state before
// its first result is registered; PADS results then follow one per cycle unless stalled,
// as the cell row shifts towards its head; the shift also clears the row.
// No hit is taken from the flush transaction until its last result is registered; a stalled
// result output holds the row still. Reset clears all cells and the pipeline, and loads
// the register defaults.
`default_nettype none

module two_layer_pad_coincidence_core import tlpc_pkg::*; #(
    parameter int PADS      = 64,
    parameter int CROSSINGS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlpc_cfg_if.sink    cfg,
    tlpc_in_if.sink     hits,
    tlpc_out_if.source  pads
);

`include "assert_macros.svh"

    localparam int CNT_W = (PADS > 1) ? $clog2(PADS) : 1;

    logic [CFG_W-1:0]     max_delta_reg;
    logic [CFG_W-1:0]     spp_reg;

    hit_info_t            info;
    logic                 take_in;
    logic                 pipe_hit_reg;
    logic                 pipe_flush_reg;
    logic                 pipe_layer_reg;
    hit_info_t            pipe_info_reg;

    logic                 flushing_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 adv;
    logic                 last;
    cell_ctrl_t           ctrl;

    logic [CROSSINGS-1:0] first_w  [PADS];
    logic [CROSSINGS-1:0] second_w [PADS];
    logic [CROSSINGS-1:0] co_full;
    logic [MASK_W-1:0]    first_m;
    logic [MASK_W-1:0]    second_m;
    logic [MASK_W-1:0]    co_m;

    logic                 out_valid_reg;
    logic [PAD_NUM_W-1:0] pad_num_reg;
    logic [MASK_W-1:0]    first_mask_reg;
    logic [MASK_W-1:0]    second_mask_reg;
    logic [MASK_W-1:0]    co_mask_reg;
    logic                 last_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delta_reg <= MAX_DELTA_BX_RESET;
            spp_reg       <= STRIPS_PER_PAD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_DELTA_BX:   max_delta_reg <= cfg.data;
                REG_STRIPS_PER_PAD: spp_reg       <= cfg.data;
                default:            ;
            endcase
        end
    end

    tlpc_pad_map #(
        .PADS      (PADS),
        .CROSSINGS (CROSSINGS)
    ) u_pad_map (
        .strip_number   (hits.strip_number),
        .crossing       (hits.crossing),
        .strips_per_pad (spp_reg),
        .info           (info)
    );

    assign hits.ready = !flushing_reg && !pipe_flush_reg;
    assign take_in    = hits.valid && hits.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_hit_reg   <= 1'b0;
            pipe_flush_reg <= 1'b0;
        end
        else
        begin
            pipe_hit_reg   <= take_in && (hits.command == CMD_HIT) && info.ok;
            pipe_flush_reg <= take_in && (hits.command == CMD_FLUSH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            pipe_layer_reg <= hits.layer_sel;
            pipe_info_reg  <= info;
        end
    end

    assign adv  = flushing_reg && (!out_valid_reg || pads.ready);
    assign last = (count_reg == CNT_W'(PADS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flushing_reg <= 1'b0;
            count_reg    <= '0;
        end
        else if (pipe_flush_reg)
        begin
            flushing_reg <= 1'b1;
            count_reg    <= '0;
        end
        else if (adv)
        begin
            count_reg <= count_reg + CNT_W'(1);
            if (last)
            begin
                flushing_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        ctrl.hit     = pipe_hit_reg;
        ctrl.layer   = pipe_layer_reg;
        ctrl.pad     = pipe_info_reg.pad;
        ctrl.bit_idx = pipe_info_reg.bit_idx;
        ctrl.shift   = adv;
    end

    for (genvar p = 0; p < PADS; p++)
    begin : g_cell
        if (p == PADS - 1)
        begin : g_tail
            tlpc_cell #(
                .CROSSINGS (CROSSINGS),
                .PAD_ID    (p)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .nb_first  ({CROSSINGS{1'b0}}),
                .nb_second ({CROSSINGS{1'b0}}),
                .first_q   (first_w[p]),
                .second_q  (second_w[p])
            );
        end
        else
        begin : g_body
            tlpc_cell #(
                .CROSSINGS (CROSSINGS),
                .PAD_ID    (p)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .nb_first  (first_w[p+1]),
                .nb_second (second_w[p+1]),
                .first_q   (first_w[p]),
                .second_q  (second_w[p])
            );
        end
    end

    // A layer-one bit counts when any layer-two bit lies within the allowed distance.
    always_comb
    begin
        logic near;
        int   span_bx;
        for (int i = 0; i < CROSSINGS; i++)
        begin
            near = 1'b0;
            for (int j = 0; j < CROSSINGS; j++)
            begin
                span_bx = (i > j) ? (i - j) : (j - i);
                if (second_w[0][j] && (span_bx <= int'(max_delta_reg)))
                begin
                    near = 1'b1;
                end
            end
            co_full[i] = first_w[0][i] && near;
        end
    end

    for (genvar k = 0; k < MASK_W; k++)
    begin : g_mask
        if (k < CROSSINGS)
        begin : g_live
            assign first_m[k]  = first_w[0][k];
            assign second_m[k] = second_w[0][k];
            assign co_m[k]     = co_full[k];
        end
        else
        begin : g_pad
            assign first_m[k]  = 1'b0;
            assign second_m[k] = 1'b0;
            assign co_m[k]     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pads.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pad_num_reg     <= PAD_NUM_W'(count_reg) + PAD_NUM_W'(1);
            first_mask_reg  <= first_m;
            second_mask_reg <= second_m;
            co_mask_reg     <= co_m;
            last_reg        <= last;
        end
    end

    assign pads.valid             = out_valid_reg;
    assign pads.pad_number        = pad_num_reg;
    assign pads.first_layer_mask  = first_mask_reg;
    assign pads.second_layer_mask = second_mask_reg;
    assign pads.coincidence_mask  = co_mask_reg;
    assign pads.last_pad          = last_reg;

    `TLPC_ASSERT_NEXT(a_flush_starts, pipe_flush_reg, flushing_reg && (count_reg == '0))
    `TLPC_ASSERT_NEXT(a_last_ends_flush, adv && last, !flushing_reg && pads.valid && pads.last_pad)
    `TLPC_ASSERT_IMP(a_no_hit_in_flush, flushing_reg, !hits.ready)

endmodule

`default_nettype wire

// ===== rtl/tlpc_cell.sv =====
// One pad cell: holds both layers' crossing bitmaps and shifts them to its neighbour.
`default_nettype none

module tlpc_cell import tlpc_pkg::*; #(
    parameter int CROSSINGS = 16,
    parameter int PAD_ID    = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic [CROSSINGS-1:0] nb_first,
    input  wire logic [CROSSINGS-1:0] nb_second,
    output logic      [CROSSINGS-1:0] first_q,
    output logic      [CROSSINGS-1:0] second_q
);

    logic [CROSSINGS-1:0] first_reg;
    logic [CROSSINGS-1:0] second_reg;
    logic [CROSSINGS-1:0] hot;
    logic                 sel;

    always_comb
    begin
        for (int k = 0; k < CROSSINGS; k++)
        begin
            hot[k] = (ctrl.bit_idx == XING_IDX_W'(k));
        end
        sel = ctrl.hit && (ctrl.pad == PAD_IDX_W'(PAD_ID));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            first_reg  <= nb_first;
            second_reg <= nb_second;
        end
        else if (sel)
        begin
            if (ctrl.layer == LAYER_SECOND)
            begin
                second_reg <= second_reg | hot;
            end
            else
            begin
                first_reg <= first_reg | hot;
            end
        end
    end

    assign first_q  = first_reg;
    assign second_q = second_reg;

endmodule

`default_nettype wire

// ===== rtl/tlpc_pad_map.sv =====
// Maps a strip and crossing to a pad index and crossing bit, flagging hits out of range.
`default_nettype none

module tlpc_pad_map import tlpc_pkg::*; #(
    parameter int PADS      = 64,
    parameter int CROSSINGS = 16
) (
    input  wire logic [STRIP_W-1:0]       strip_number,
    input  wire logic signed [XING_W-1:0] crossing,
    input  wire logic [CFG_W-1:0]         strips_per_pad,
    output hit_info_t                     info
);

    logic [STRIP_W-1:0]  strip_m1;
    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot;
    logic signed [6:0]   bit_sum;
    logic                pad_ok;
    logic                bit_ok;

    always_comb
    begin
        strip_m1 = strip_number - STRIP_W'(1);
        prod     = PROD_W'(strip_m1) * PROD_W'(recip(strips_per_pad));
        quot     = prod[PROD_W-1:RECIP_SHIFT];
        pad_ok   = (strip_number != '0) && (quot < QUOT_W'(PADS));
        bit_sum  = 7'(crossing) + 7'(CROSSINGS / 2);
        bit_ok   = !bit_sum[6] && ({1'b0, bit_sum[5:0]} < 7'(CROSSINGS));

        info.ok      = pad_ok && bit_ok;
        info.pad     = quot[PAD_IDX_W-1:0];
        info.bit_idx = bit_sum[XING_IDX_W-1:0];
    end

endmodule

`default_nettype wire
